[sv/trick_play_frame_selector_defines.svh]
// Assertion helpers for the selector RTL.
`ifndef TRICK_PLAY_FRAME_SELECTOR_DEFINES_SVH
`define TRICK_PLAY_FRAME_SELECTOR_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define TPFS_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled during reset.
`define TPFS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[sv/tpfs_pkg.sv]
package tpfs_pkg;

    localparam int TIME_WIDTH       = 64;
    localparam int DIGIT_WIDTH      = 4;
    localparam int NUM_DIGITS       = TIME_WIDTH / DIGIT_WIDTH;
    localparam int DIGIT_CNT_WIDTH  = $clog2(NUM_DIGITS);
    localparam int THR_WIDTH        = 32;
    localparam int SPEED_WIDTH      = 8;
    localparam int CFG_INDEX_WIDTH  = 1;
    localparam int CFG_DATA_WIDTH   = 32;

    localparam logic [1:0] KIND_HEADER = 2'd0;
    localparam logic [1:0] KIND_I      = 2'd1;
    localparam logic [1:0] KIND_P      = 2'd2;
    localparam logic [1:0] KIND_OTHER  = 2'd3;

    localparam logic [1:0] DEC_WAIT = 2'd0;
    localparam logic [1:0] DEC_PLAY = 2'd1;
    localparam logic [1:0] DEC_SKIP = 2'd2;

    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_PLAY_SPEED     = 1'd0;
    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_SYNC_THRESHOLD = 1'd1;

    localparam logic [SPEED_WIDTH-1:0] SPEED_ONE   = 8'd1;
    localparam logic [SPEED_WIDTH-1:0] SPEED_RESET = 8'd1;
    localparam logic [THR_WIDTH-1:0]   THR_RESET   = 32'd100;

    typedef struct packed {
        logic [1:0]            frame_kind;
        logic [TIME_WIDTH-1:0] frame_time;
        logic [TIME_WIDTH-1:0] reference_time;
    } t_frame;

    typedef struct packed {
        logic [1:0] decision;
        logic       resync;
        logic       restart_clock;
    } t_result;

    typedef struct packed {
        logic same;   // frame_time equals previous timestamp
        logic late;   // reference_time < frame_time
        logic over;   // reference_time - frame_time > threshold
    } t_scan_flags;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_CFG
    } t_fsm;

endpackage

[sv/tpfs_stream_if.sv]
interface tpfs_stream_if #(
    parameter type t_payload = logic
);
    logic     valid;
    logic     ready;
    t_payload payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

[sv/tpfs_time_scan.sv]
module tpfs_time_scan
    import tpfs_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_start,
    input  logic [TIME_WIDTH-1:0] i_frame_time,
    input  logic [TIME_WIDTH-1:0] i_reference_time,
    input  logic [TIME_WIDTH-1:0] i_previous_time,
    input  logic [THR_WIDTH-1:0]  i_threshold,
    output logic                  o_done,
    output t_scan_flags           o_flags,
    output logic [TIME_WIDTH-1:0] o_frame_time
);

    logic                       r_busy;
    logic                       r_done;
    logic [DIGIT_CNT_WIDTH-1:0] r_cnt;
    logic [TIME_WIDTH-1:0]      r_ft;
    logic [TIME_WIDTH-1:0]      r_rt;
    logic [TIME_WIDTH-1:0]      r_prev;
    logic [THR_WIDTH-1:0]       r_thr;
    logic                       r_borrow;
    logic                       r_eq;
    logic                       r_gt;

    logic [DIGIT_WIDTH:0]   sub;
    logic [DIGIT_WIDTH-1:0] d_digit;
    logic [DIGIT_WIDTH-1:0] t_digit;
    logic                   last_digit;

    // LSB-first: rt - ft with ripple borrow, diff vs threshold by last differing digit
    assign sub = {1'b0, r_rt[DIGIT_WIDTH-1:0]} - {1'b0, r_ft[DIGIT_WIDTH-1:0]}
               - {{DIGIT_WIDTH{1'b0}}, r_borrow};
    assign d_digit    = sub[DIGIT_WIDTH-1:0];
    assign t_digit    = r_thr[DIGIT_WIDTH-1:0];
    assign last_digit = (r_cnt == DIGIT_CNT_WIDTH'(NUM_DIGITS - 1));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else if (r_busy) begin
            r_cnt <= r_cnt + 1'b1;
            if (last_digit) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_ft     <= i_frame_time;
            r_rt     <= i_reference_time;
            r_prev   <= i_previous_time;
            r_thr    <= i_threshold;
            r_borrow <= 1'b0;
            r_eq     <= 1'b1;
            r_gt     <= 1'b0;
        end else if (r_busy) begin
            // ft rotates so the whole word is back in place at the end
            r_ft     <= {r_ft[DIGIT_WIDTH-1:0], r_ft[TIME_WIDTH-1:DIGIT_WIDTH]};
            r_rt     <= r_rt >> DIGIT_WIDTH;
            r_prev   <= r_prev >> DIGIT_WIDTH;
            r_thr    <= r_thr >> DIGIT_WIDTH;
            r_borrow <= sub[DIGIT_WIDTH];
            r_eq     <= r_eq && (r_ft[DIGIT_WIDTH-1:0] == r_prev[DIGIT_WIDTH-1:0]);
            if (d_digit > t_digit) begin
                r_gt <= 1'b1;
            end else if (d_digit < t_digit) begin
                r_gt <= 1'b0;
            end
        end
    end

    assign o_done       = r_done;
    assign o_flags      = '{same: r_eq, late: r_borrow, over: r_gt};
    assign o_frame_time = r_ft;

endmodule

[sv/tpfs_serial_div.sv]
module tpfs_serial_div #(
    parameter int DW = 16
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  logic [DW-1:0] i_dividend,
    input  logic [DW:0]   i_divisor,
    output logic          o_done,
    output logic [DW-1:0] o_quotient
);

    localparam int CNT_W = $clog2(DW);

    logic             r_busy;
    logic             r_done;
    logic [CNT_W-1:0] r_cnt;
    logic [DW-1:0]    r_quo;
    logic [DW-1:0]    r_rem;
    logic [DW:0]      r_divisor;

    logic [DW:0] trial;
    logic [DW:0] diff;
    logic        ge;

    // restoring division, one quotient bit per cycle, dividend shifts out of r_quo
    assign trial = {r_rem, r_quo[DW-1]};
    assign diff  = trial - r_divisor;
    assign ge    = (trial >= r_divisor);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b1;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else if (r_busy) begin
            r_cnt <= r_cnt + 1'b1;
            if (r_cnt == CNT_W'(DW - 1)) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo     <= i_dividend;
            r_rem     <= '0;
            r_divisor <= i_divisor;
        end else if (r_busy) begin
            r_quo <= {r_quo[DW-2:0], ge};
            r_rem <= ge ? diff[DW-1:0] : trial[DW-1:0];
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_quo;

endmodule

[sv/trick_play_frame_selector.sv]
// A result is registered when the 4-bit digit-serial timestamp scan (16 digits) and the
// one-bit-per-cycle divider, when started for an I frame, are both done and the output
// register is free; the block takes no new frame until that result is registered.
// A nonzero even play_speed write runs the divider; no frame is taken meanwhile.
// Reset: synchronous, active low; control registers and counters return to their reset values.
module trick_play_frame_selector
    import tpfs_pkg::*;
#(
    parameter int COUNT_WIDTH        = 16,
    parameter int INITIAL_GOP_LENGTH = 200
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    tpfs_stream_if.sink                i_frame,
    tpfs_stream_if.source              o_result,
    input  logic                       i_cfg_we,
    input  logic [CFG_INDEX_WIDTH-1:0] i_cfg_index,
    input  logic [CFG_DATA_WIDTH-1:0]  i_cfg_data
);

    `include "trick_play_frame_selector_defines.svh"

    localparam int CW = COUNT_WIDTH;

    // control and state
    t_fsm                    r_fsm, n_fsm;
    logic [SPEED_WIDTH-1:0]  r_speed, n_speed;
    logic [THR_WIDTH-1:0]    r_thr, n_thr;
    logic [CW-1:0]           r_p_count, n_p_count;
    logic [CW-1:0]           r_fsd, n_fsd;
    logic                    r_dropping, n_dropping;
    logic [TIME_WIDTH-1:0]   r_prev, n_prev;
    logic [CW-1:0]           r_gop, n_gop;
    logic [CW:0]             r_skip, n_skip;   // two's complement
    logic                    r_out_valid, n_out_valid;

    // per-item payload
    logic [1:0]              r_kind, n_kind;
    logic                    r_drop_i, n_drop_i;
    logic                    r_div_skip, n_div_skip;
    t_result                 r_out, n_out;

    // submodule hookup
    logic                    scan_start;
    logic                    scan_done;
    t_scan_flags             scan_flags;
    logic [TIME_WIDTH-1:0]   scan_ft;
    logic                    div_start;
    logic [CW-1:0]           div_dividend;
    logic [CW:0]             div_divisor;
    logic                    div_done;
    logic [CW-1:0]           div_quotient;
    logic                    frame_ready;

    // item decode
    t_frame                  frame;
    logic                    speed_pos;
    logic                    speed_gt1;
    logic [CW-1:0]           gop_new;
    logic [CW:0]             gop_inc;
    logic [CW:0]             speed_ext;
    logic                    drop_cond;

    // config decode
    logic [SPEED_WIDTH-1:0]  cfg_speed;
    logic [SPEED_WIDTH-1:0]  cfg_mag;
    logic                    cfg_one;
    logic                    cfg_even;

    // commit values
    logic [CW-1:0]           c_pc;
    logic [CW-1:0]           c_fsd;
    logic                    c_drop;
    logic [CW:0]             c_skip;
    logic                    skip_hit;
    t_result                 c_result;

    assign frame     = i_frame.payload;
    assign speed_pos = !r_speed[SPEED_WIDTH-1] && (r_speed != '0);
    assign speed_gt1 = speed_pos && (r_speed != SPEED_ONE);
    assign gop_new   = (r_p_count != '0) ? r_p_count : r_gop;
    assign gop_inc   = (CW+1)'(gop_new) + (CW+1)'(1);
    assign speed_ext = (CW+1)'(r_speed[SPEED_WIDTH-2:0]);
    assign drop_cond = speed_pos && (speed_ext > gop_inc);

    assign cfg_speed = i_cfg_data[SPEED_WIDTH-1:0];
    assign cfg_mag   = cfg_speed[SPEED_WIDTH-1] ? (~cfg_speed + 1'b1) : cfg_speed;
    assign cfg_one   = (cfg_speed == SPEED_ONE);
    assign cfg_even  = (cfg_speed != '0) && !cfg_speed[0];

    tpfs_time_scan u_scan (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_start          (scan_start),
        .i_frame_time     (frame.frame_time),
        .i_reference_time (frame.reference_time),
        .i_previous_time  (r_prev),
        .i_threshold      (r_thr),
        .o_done           (scan_done),
        .o_flags          (scan_flags),
        .o_frame_time     (scan_ft)
    );

    tpfs_serial_div #(
        .DW (CW)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (div_dividend),
        .i_divisor  (div_divisor),
        .o_done     (div_done),
        .o_quotient (div_quotient)
    );

    // counter and decision update for the item under work
    always_comb begin
        c_pc     = r_p_count;
        c_fsd    = r_fsd;
        c_drop   = r_dropping;
        c_skip   = r_skip;
        skip_hit = 1'b0;
        if (r_kind != KIND_HEADER) begin
            if (r_kind == KIND_I) begin
                c_pc = '0;
                if (speed_pos) begin
                    if (r_drop_i) begin
                        // quotient is the GOP drop rate here
                        c_skip = '1;
                        c_drop = 1'b1;
                        if (r_fsd != '0) begin
                            if (r_fsd < div_quotient) begin
                                skip_hit = 1'b1;
                            end else begin
                                c_fsd = '0;
                            end
                        end
                    end else begin
                        c_drop = 1'b0;
                        if (r_div_skip) begin
                            c_skip = {1'b0, div_quotient};
                        end
                        if (c_skip[CW] || (c_skip == '0)) begin
                            skip_hit = 1'b1;
                        end
                    end
                end
            end else if (r_kind == KIND_P) begin
                if (!scan_flags.same) begin
                    c_pc = (&r_p_count) ? r_p_count : r_p_count + 1'b1;
                end
                if (r_dropping) begin
                    skip_hit = 1'b1;
                end
            end
            if (!scan_flags.same) begin
                c_fsd = (&c_fsd) ? c_fsd : c_fsd + 1'b1;
            end
            if (speed_gt1 && !c_drop && (c_skip[CW] || (c_pc >= c_skip[CW-1:0]))) begin
                skip_hit = 1'b1;
            end
        end

        c_result = '{decision: DEC_PLAY, resync: 1'b0, restart_clock: 1'b0};
        if (r_kind == KIND_HEADER) begin
            c_result.restart_clock = 1'b1;
        end else if (skip_hit) begin
            c_result.decision = DEC_SKIP;
        end else if (scan_flags.late) begin
            c_result.decision = DEC_WAIT;
        end else begin
            c_result.resync = scan_flags.over;
        end
    end

    always_comb begin
        n_fsm        = r_fsm;
        n_speed      = r_speed;
        n_thr        = r_thr;
        n_p_count    = r_p_count;
        n_fsd        = r_fsd;
        n_dropping   = r_dropping;
        n_prev       = r_prev;
        n_gop        = r_gop;
        n_skip       = r_skip;
        n_out_valid  = r_out_valid && !o_result.ready;
        n_kind       = r_kind;
        n_drop_i     = r_drop_i;
        n_div_skip   = r_div_skip;
        n_out        = r_out;
        scan_start   = 1'b0;
        div_start    = 1'b0;
        div_dividend = '0;
        div_divisor  = '0;
        frame_ready  = 1'b0;

        case (r_fsm)
            ST_IDLE: begin
                frame_ready = !i_cfg_we;
                if (i_frame.valid && !i_cfg_we) begin
                    scan_start = 1'b1;
                    n_kind     = frame.frame_kind;
                    n_drop_i   = 1'b0;
                    n_div_skip = 1'b0;
                    n_fsm      = ST_RUN;
                    if (frame.frame_kind == KIND_I) begin
                        n_gop = gop_new;
                        if (drop_cond) begin
                            div_start    = 1'b1;
                            div_dividend = speed_ext[CW-1:0];
                            div_divisor  = gop_inc;
                            n_drop_i     = 1'b1;
                        end else if (speed_pos && (r_p_count != '0)) begin
                            div_start    = 1'b1;
                            div_dividend = gop_new;
                            div_divisor  = speed_ext;
                            n_div_skip   = 1'b1;
                        end
                    end
                end
            end
            ST_RUN: begin
                if (scan_done && div_done && (!r_out_valid || o_result.ready)) begin
                    n_p_count   = c_pc;
                    n_fsd       = c_fsd;
                    n_dropping  = c_drop;
                    n_skip      = c_skip;
                    n_prev      = scan_flags.same ? r_prev : scan_ft;
                    n_out       = c_result;
                    n_out_valid = 1'b1;
                    n_fsm       = ST_IDLE;
                end
            end
            ST_CFG: begin
                if (div_done) begin
                    n_skip = {1'b0, div_quotient};
                    n_fsm  = ST_IDLE;
                end
            end
            default: begin
                n_fsm = ST_IDLE;
            end
        endcase

        // the user must write only between items (not enforced); accepted speed writes override a pending one
        if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_PLAY_SPEED: begin
                    if (cfg_one) begin
                        n_speed = SPEED_ONE;
                        n_skip  = {1'b0, r_gop};
                        n_fsm   = ST_IDLE;
                    end else if (cfg_even) begin
                        n_speed      = cfg_speed;
                        div_start    = 1'b1;
                        div_dividend = r_gop;
                        div_divisor  = (CW+1)'(cfg_mag);
                        n_fsm        = ST_CFG;
                    end
                end
                CFG_SYNC_THRESHOLD: begin
                    n_thr = i_cfg_data[THR_WIDTH-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fsm       <= ST_IDLE;
            r_speed     <= SPEED_RESET;
            r_thr       <= THR_RESET;
            r_p_count   <= '0;
            r_fsd       <= '0;
            r_dropping  <= 1'b0;
            r_prev      <= '0;
            r_gop       <= CW'(INITIAL_GOP_LENGTH);
            r_skip      <= (CW+1)'(INITIAL_GOP_LENGTH);
            r_out_valid <= 1'b0;
        end else begin
            r_fsm       <= n_fsm;
            r_speed     <= n_speed;
            r_thr       <= n_thr;
            r_p_count   <= n_p_count;
            r_fsd       <= n_fsd;
            r_dropping  <= n_dropping;
            r_prev      <= n_prev;
            r_gop       <= n_gop;
            r_skip      <= n_skip;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_kind     <= n_kind;
        r_drop_i   <= n_drop_i;
        r_div_skip <= n_div_skip;
        r_out      <= n_out;
    end

    assign i_frame.ready    = frame_ready;
    assign o_result.valid   = r_out_valid;
    assign o_result.payload = r_out;

    `TPFS_ASSERT_NOW(a_resync_only_on_play, i_clk, i_rst_n, o_result.valid && o_result.payload.resync, o_result.payload.decision == DEC_PLAY && !o_result.payload.restart_clock, "resync on a result that is not a clock-checked play")
    `TPFS_ASSERT_NOW(a_restart_plays, i_clk, i_rst_n, o_result.valid && o_result.payload.restart_clock, o_result.payload.decision == DEC_PLAY, "header beat not played")
    `TPFS_ASSERT_NEXT(a_accept_starts_scan, i_clk, i_rst_n, i_frame.valid && i_frame.ready, r_fsm == ST_RUN && !scan_done, "accepted beat did not start the timestamp scan")

endmodule

[verif/trick_play_frame_selector_checker.sv]
module trick_play_frame_selector_checker
    import tpfs_pkg::*;
#(
    parameter int COUNT_WIDTH        = 16,
    parameter int INITIAL_GOP_LENGTH = 200
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_frame_valid,
    input  logic                       i_frame_ready,
    input  t_frame                     i_frame,
    input  logic                       i_result_valid,
    input  logic                       i_result_ready,
    input  t_result                    i_result,
    input  logic                       i_cfg_we,
    input  logic [CFG_INDEX_WIDTH-1:0] i_cfg_index,
    input  logic [CFG_DATA_WIDTH-1:0]  i_cfg_data,
    output int                         o_fail_count,
    output int                         o_pending,
    output int                         o_checked
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = '1;
    localparam int MAX_REPORTS = 10;

    // shadow copy of the selector state
    logic signed [SPEED_WIDTH-1:0] speed;
    logic [THR_WIDTH-1:0]          threshold;
    logic [COUNT_WIDTH-1:0]        p_frames;
    logic [COUNT_WIDTH-1:0]        since_drop;
    logic                          gop_drop;
    logic [TIME_WIDTH-1:0]         last_time;
    logic [COUNT_WIDTH-1:0]        gop_len;
    logic signed [COUNT_WIDTH:0]   p_skip_at;

    t_result expected_decisions[$];
    int      fail_count = 0;
    int      checked = 0;

    function automatic logic [COUNT_WIDTH-1:0] sat_inc(input logic [COUNT_WIDTH-1:0] v);
        return (v == COUNT_MAX) ? v : v + 1'b1;
    endfunction

    task automatic clear_state();
        speed      = SPEED_RESET;
        threshold  = THR_RESET;
        p_frames   = '0;
        since_drop = '0;
        gop_drop   = 1'b0;
        last_time  = '0;
        gop_len    = COUNT_WIDTH'(INITIAL_GOP_LENGTH);
        p_skip_at  = (COUNT_WIDTH+1)'(INITIAL_GOP_LENGTH);
    endtask

    task automatic apply_cfg(input logic [CFG_INDEX_WIDTH-1:0] index,
                             input logic [CFG_DATA_WIDTH-1:0] data);
        logic [SPEED_WIDTH-1:0] raw;
        logic [SPEED_WIDTH:0]   mag;
        raw = data[SPEED_WIDTH-1:0];
        mag = raw[SPEED_WIDTH-1] ? ({1'b0, ~raw} + 1'b1) : {1'b0, raw};
        case (index)
            CFG_PLAY_SPEED: begin
                // speed 1 and nonzero even speeds only; anything else leaves state alone
                if (raw == SPEED_ONE) begin
                    speed     = raw;
                    p_skip_at = {1'b0, gop_len};
                end else if (mag != 0 && !mag[0]) begin
                    speed     = raw;
                    p_skip_at = {1'b0, gop_len / mag};
                end
            end
            CFG_SYNC_THRESHOLD: threshold = data[THR_WIDTH-1:0];
            default: ;
        endcase
    endtask

    task automatic predict_decision(input t_frame f, output t_result r);
        logic                   same;
        logic                   decided;
        logic [1:0]             dec;
        logic [SPEED_WIDTH-1:0] uspeed;
        logic [COUNT_WIDTH:0]   gop_plus;
        logic [COUNT_WIDTH-1:0] rate;
        logic [TIME_WIDTH-1:0]  lag;
        same    = (f.frame_time == last_time);
        decided = 1'b0;
        dec     = DEC_PLAY;
        uspeed  = speed;
        r       = '0;
        if (f.frame_kind == KIND_HEADER) begin
            decided         = 1'b1;
            r.restart_clock = 1'b1;
        end else begin
            case (f.frame_kind)
                KIND_I: begin
                    if (p_frames != 0) begin
                        gop_len  = p_frames;
                        p_frames = '0;
                        if (speed > 0)
                            p_skip_at = {1'b0, gop_len / uspeed};
                    end
                    if (speed > 0) begin
                        gop_plus = {1'b0, gop_len} + 1'b1;
                        if (uspeed > gop_plus) begin
                            // drop whole GOPs
                            rate      = COUNT_WIDTH'(uspeed / gop_plus);
                            p_skip_at = '1;
                            p_frames  = '0;
                            gop_drop  = 1'b1;
                            if (since_drop != 0) begin
                                if (since_drop < rate) begin
                                    decided = 1'b1;
                                    dec     = DEC_SKIP;
                                end else begin
                                    since_drop = '0;
                                end
                            end
                        end else begin
                            gop_drop = 1'b0;
                            if ($signed({1'b0, p_frames}) >= p_skip_at) begin
                                decided = 1'b1;
                                dec     = DEC_SKIP;
                            end
                        end
                    end
                end
                KIND_P: begin
                    if (!same)
                        p_frames = sat_inc(p_frames);
                    if (gop_drop) begin
                        decided = 1'b1;
                        dec     = DEC_SKIP;
                    end
                end
                default: ;
            endcase
            if (!same)
                since_drop = sat_inc(since_drop);
            if (speed > 1 && !gop_drop && $signed({1'b0, p_frames}) >= p_skip_at) begin
                decided = 1'b1;
                dec     = DEC_SKIP;
            end
        end
        if (!same)
            last_time = f.frame_time;
        if (!decided) begin
            if (f.frame_time <= f.reference_time) begin
                dec = DEC_PLAY;
                lag = f.reference_time - f.frame_time;
                if (lag > {{(TIME_WIDTH-THR_WIDTH){1'b0}}, threshold})
                    r.resync = 1'b1;
            end else begin
                dec = DEC_WAIT;
            end
        end
        r.decision = dec;
    endtask

    always @(posedge i_clk) begin : watch
        t_result want;
        if (!i_rst_n) begin
            clear_state();
            expected_decisions.delete();
        end else begin
            if (i_cfg_we)
                apply_cfg(i_cfg_index, i_cfg_data);
            if (i_frame_valid && i_frame_ready) begin
                predict_decision(i_frame, want);
                expected_decisions.push_back(want);
            end
            if (i_result_valid && i_result_ready) begin
                if (expected_decisions.size() == 0) begin
                    fail_count++;
                    if (fail_count <= MAX_REPORTS)
                        $display("result beat with no frame outstanding: %s=%0d %s=%0d %s=%0d",
                                 "decision", i_result.decision, "resync", i_result.resync,
                                 "restart", i_result.restart_clock);
                end else begin
                    want = expected_decisions.pop_front();
                    checked++;
                    if (i_result.decision !== want.decision || i_result.resync !== want.resync ||
                        i_result.restart_clock !== want.restart_clock) begin
                        fail_count++;
                        if (fail_count <= MAX_REPORTS)
                            $display({"result %0d: expected decision=%0d resync=%0d ",
                                      "restart=%0d, got decision=%0d resync=%0d restart=%0d"},
                                     checked, want.decision, want.resync, want.restart_clock,
                                     i_result.decision, i_result.resync,
                                     i_result.restart_clock);
                    end
                end
            end
        end
        o_fail_count <= fail_count;
        o_pending    <= expected_decisions.size();
        o_checked    <= checked;
    end

endmodule

[verif/trick_play_frame_selector_tb.sv]
module trick_play_frame_selector_tb;
    import tpfs_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    // narrow counters so saturation is reached within a short run
    localparam int COUNT_WIDTH        = 8;
    localparam int INITIAL_GOP_LENGTH = 200;
    // slowest run: ~1.45k frames with gaps and stalls; the cycle limit leaves ~4x margin
    localparam int CYCLE_LIMIT        = 500_000;
    localparam int SETTLE_CYCLES      = 40;
    localparam int HOLDOFF_CYCLES     = 600;
    localparam int SAT_FRAMES         = 300;
    localparam int PHASE_FRAMES       = 260;
    localparam logic [TIME_WIDTH-1:0] TIME_MAX = '1;
    localparam logic [THR_WIDTH-1:0]  THR_MAX  = '1;

    logic                       i_clk = 1'b0;
    logic                       i_rst_n = 1'b0;
    logic                       i_cfg_we = 1'b0;
    logic [CFG_INDEX_WIDTH-1:0] i_cfg_index = '0;
    logic [CFG_DATA_WIDTH-1:0]  i_cfg_data = '0;

    tpfs_stream_if #(.t_payload(t_frame))  frame_if ();
    tpfs_stream_if #(.t_payload(t_result)) result_if ();

    int fail_count;
    int pending;
    int checked;
    int frames_sent = 0;
    int cycle_count = 0;
    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int holdoff_requests = 0;
    int holdoff_served = 0;
    int holdoff_left = 0;
    logic [TIME_WIDTH-1:0] stream_time = '0;
    logic [THR_WIDTH-1:0]  cur_threshold = THR_RESET;

    trick_play_frame_selector #(
        .COUNT_WIDTH       (COUNT_WIDTH),
        .INITIAL_GOP_LENGTH(INITIAL_GOP_LENGTH)
    ) DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_frame    (frame_if.sink),
        .o_result   (result_if.source),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_index(i_cfg_index),
        .i_cfg_data (i_cfg_data)
    );

    trick_play_frame_selector_checker #(
        .COUNT_WIDTH       (COUNT_WIDTH),
        .INITIAL_GOP_LENGTH(INITIAL_GOP_LENGTH)
    ) u_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_frame_valid (frame_if.valid),
        .i_frame_ready (frame_if.ready),
        .i_frame       (frame_if.payload),
        .i_result_valid(result_if.valid),
        .i_result_ready(result_if.ready),
        .i_result      (result_if.payload),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .o_fail_count  (fail_count),
        .o_pending     (pending),
        .o_checked     (checked)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results outstanding", cycle_count, pending);
            $display("trick_play_frame_selector test failed");
            $finish;
        end
    end

    // long receiver hold-off, so the block backs up into its input
    always @(posedge i_clk) begin
        if (holdoff_served != holdoff_requests) begin
            holdoff_served <= holdoff_requests;
            holdoff_left   <= HOLDOFF_CYCLES;
        end else if (holdoff_left > 0) begin
            holdoff_left <= holdoff_left - 1;
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || holdoff_left > 0)
            result_if.ready <= 1'b0;
        else
            result_if.ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    task automatic send_frame(input logic [1:0] kind, input logic [TIME_WIDTH-1:0] ft,
                              input logic [TIME_WIDTH-1:0] rt);
        t_frame f;
        int     gap;
        f.frame_kind     = kind;
        f.frame_time     = ft;
        f.reference_time = rt;
        gap = 0;
        while (send_idle_pct != 0 && gap < 50 && $urandom_range(99) < send_idle_pct)
            gap++;
        if (gap != 0) begin
            frame_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        frame_if.valid   <= 1'b1;
        frame_if.payload <= f;
        @(posedge i_clk);
        while (!frame_if.ready)
            @(posedge i_clk);
        frames_sent++;
    endtask

    task automatic write_reg(input logic [CFG_INDEX_WIDTH-1:0] index,
                             input logic [CFG_DATA_WIDTH-1:0] data);
        frame_if.valid <= 1'b0;
        // let the count of outstanding results take in the last accepted beat
        @(posedge i_clk);
        while (pending != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= index;
        i_cfg_data  <= data;
        if (index == CFG_SYNC_THRESHOLD)
            cur_threshold = data[THR_WIDTH-1:0];
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic write_speed(input logic [SPEED_WIDTH-1:0] s);
        write_reg(CFG_PLAY_SPEED, {24'($urandom_range(0, (1 << 24) - 1)), s});
    endtask

    function automatic logic [TIME_WIDTH-1:0] pick_ref(input logic [TIME_WIDTH-1:0] ft);
        case ($urandom_range(9))
            0:       return ft - $urandom_range(1, 30);
            1:       return ft + cur_threshold + $urandom_range(1, 50);
            2:       return ft + cur_threshold;
            3:       return ft;
            default: return ft + $urandom_range(0, 20);
        endcase
    endfunction

    task automatic advance_time();
        // occasional repeated timestamp
        if ($urandom_range(19) != 0)
            stream_time = stream_time + $urandom_range(1, 40);
    endtask

    task automatic send_gop(input int p_frames);
        advance_time();
        send_frame(KIND_I, stream_time, pick_ref(stream_time));
        for (int i = 0; i < p_frames; i++) begin
            advance_time();
            send_frame(($urandom_range(7) == 0) ? KIND_OTHER : KIND_P, stream_time,
                       pick_ref(stream_time));
        end
    endtask

    task automatic random_frames(input int count);
        int target;
        int pick;
        target = frames_sent + count;
        while (frames_sent < target) begin
            pick = $urandom_range(99);
            if (pick < 8) begin
                send_frame(2'($urandom_range(3)), {$urandom, $urandom}, {$urandom, $urandom});
            end else if (pick < 11) begin
                advance_time();
                send_frame(KIND_HEADER, stream_time, pick_ref(stream_time));
            end else begin
                pick = $urandom_range(9);
                if (pick < 6)
                    send_gop($urandom_range(0, 6));
                else if (pick < 9)
                    send_gop($urandom_range(7, 30));
                else
                    send_gop(0);
            end
        end
    endtask

    task automatic set_idle(input int send_pct, input int recv_pct);
        send_idle_pct = send_pct;
        recv_stall_pct <= recv_pct;
    endtask

    initial begin
        frame_if.valid   <= 1'b0;
        frame_if.payload <= '0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: reset state, learning, skipping, drop mode, rejected speeds, extremes
        send_frame(KIND_P, 64'd0, 64'd0);
        send_frame(KIND_HEADER, 64'd10, 64'd5);
        send_frame(KIND_I, 64'd20, 64'd20);
        send_frame(KIND_P, 64'd30, 64'd25);
        send_frame(KIND_P, 64'd40, 64'd141);
        send_frame(KIND_OTHER, 64'd50, 64'd150);
        send_frame(KIND_P, 64'd50, 64'd150);
        send_frame(KIND_I, 64'd60, 64'd60);
        write_speed(8'd2);
        send_frame(KIND_P, 64'd70, 64'd70);
        send_frame(KIND_I, 64'd80, 64'd80);
        write_speed(8'd8);
        send_frame(KIND_P, 64'd90, 64'd90);
        send_frame(KIND_I, 64'd100, 64'd100);
        send_frame(KIND_P, 64'd110, 64'd110);
        send_frame(KIND_I, 64'd120, 64'd120);
        send_frame(KIND_I, 64'd130, 64'd130);
        write_speed(8'd3);
        write_speed(8'd0);
        write_speed(8'h7f);
        write_speed(-8'sd2);
        send_frame(KIND_I, 64'd140, 64'd140);
        send_frame(KIND_P, 64'd150, 64'd150);
        write_speed(8'h80);
        write_reg(CFG_SYNC_THRESHOLD, '0);
        send_frame(KIND_OTHER, 64'd160, 64'd161);
        write_reg(CFG_SYNC_THRESHOLD, THR_MAX);
        send_frame(KIND_P, TIME_MAX, TIME_MAX);
        send_frame(KIND_OTHER, 64'd0, TIME_MAX);
        send_frame(KIND_HEADER, TIME_MAX, 64'd0);
        write_speed(SPEED_ONE);
        send_frame(KIND_I, 64'd5, 64'd5);

        // no idling
        write_reg(CFG_SYNC_THRESHOLD, 32'd1000);
        stream_time = {$urandom, $urandom};
        random_frames(PHASE_FRAMES);

        // sender idles; fast speed so small GOPs go into drop mode
        set_idle(60, 0);
        write_speed(SPEED_WIDTH'($urandom));
        write_speed(8'd64);
        write_reg(CFG_SYNC_THRESHOLD, '0);
        random_frames(PHASE_FRAMES);

        // long P run to saturate both frame counters
        set_idle(0, 0);
        write_speed(8'd2);
        write_reg(CFG_SYNC_THRESHOLD, $urandom);
        for (int i = 0; i < SAT_FRAMES; i++) begin
            stream_time = stream_time + 1;
            send_frame(KIND_P, stream_time, pick_ref(stream_time));
        end
        send_gop(3);
        write_speed(8'd126);
        random_frames(40);

        // receiver stalls, with one long hold-off up front
        set_idle(0, 60);
        write_speed(-8'sd2);
        write_reg(CFG_SYNC_THRESHOLD, THR_MAX);
        holdoff_requests <= holdoff_requests + 1;
        random_frames(PHASE_FRAMES);

        // both sides idle now and then
        set_idle(9, 9);
        write_speed(SPEED_WIDTH'($urandom));
        write_reg(CFG_SYNC_THRESHOLD, $urandom_range(0, 200));
        random_frames(PHASE_FRAMES / 2);
        write_speed(8'd126);
        random_frames(PHASE_FRAMES / 2);

        frame_if.valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        $display("%0d frames sent, %0d decisions checked, %0d failures", frames_sent, checked,
                 fail_count);
        $display("covered GOP learning and drop, counter saturation, resync, rejected speeds");
        if (fail_count == 0)
            $display("trick_play_frame_selector test passed");
        else
            $display("trick_play_frame_selector test failed");
        $finish;
    end

endmodule
